/* design/huffman_stream_decoder_macros.svh */
// Assertion helpers shared by the decoder.
`ifndef HUFFMAN_STREAM_DECODER_MACROS_SVH
`define HUFFMAN_STREAM_DECODER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define HSD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define HSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/hsd_pkg.sv */
package hsd_pkg;

    localparam int unsigned SYM_W = 8;

    // Parsing phase of the current stream.
    typedef enum logic [1:0] {
        PH_PAD  = 2'd0,
        PH_TREE = 2'd1,
        PH_WALK = 2'd2
    } t_phase;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BIT,
        ST_POP,
        ST_W1,
        ST_W2,
        ST_FLUSH
    } t_state;

endpackage

/* design/hsd_node_mem.sv */
module hsd_node_mem #(
    parameter int unsigned NODES = 511,
    parameter int unsigned NW    = 9
) (
    input  logic                     i_clk,
    input  logic                     i_left_we,
    input  logic                     i_right_we,
    input  logic [NW-1:0]            i_link_addr,
    input  logic [NW-1:0]            i_link_data,
    input  logic                     i_leaf_we,
    input  logic [NW-1:0]            i_leaf_waddr,
    input  logic [hsd_pkg::SYM_W:0]  i_leaf_wdata,
    input  logic                     i_link_re,
    input  logic [NW-1:0]            i_link_raddr,
    output logic [NW-1:0]            o_left,
    output logic [NW-1:0]            o_right,
    input  logic                     i_leaf_re,
    input  logic [NW-1:0]            i_leaf_raddr,
    output logic [hsd_pkg::SYM_W:0]  o_leaf
);
    import hsd_pkg::*;

    logic [NW-1:0]  r_left  [NODES];
    logic [NW-1:0]  r_right [NODES];
    logic [SYM_W:0] r_leaf  [NODES];

    // Child links: one side written per beat of tree building.
    always_ff @(posedge i_clk) begin
        if (i_left_we) begin
            r_left[i_link_addr] <= i_link_data;
        end
        if (i_right_we) begin
            r_right[i_link_addr] <= i_link_data;
        end
        if (i_link_re) begin
            o_left  <= r_left[i_link_raddr];
            o_right <= r_right[i_link_raddr];
        end
    end

    // Leaf flag and symbol value.
    always_ff @(posedge i_clk) begin
        if (i_leaf_we) begin
            r_leaf[i_leaf_waddr] <= i_leaf_wdata;
        end
        if (i_leaf_re) begin
            o_leaf <= r_leaf[i_leaf_raddr];
        end
    end

endmodule

/* design/hsd_stack_mem.sv */
module hsd_stack_mem #(
    parameter int unsigned DEPTH = 256,
    parameter int unsigned AW    = 8,
    parameter int unsigned DW    = 10
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    import hsd_pkg::*;

    logic [DW-1:0] r_mem [DEPTH];

    // Parent entries below the cached top of stack.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

/* design/huffman_stream_decoder.sv */
// Channel   Dir  Fields (low bit up)                 Meaning
// s_axis    in   tdata: in_byte; tuser: stream_start  compressed bytes
// m_axis    out  tdata: symbol; tlast: last           decoded symbols
//
// One byte passes through the accept state, one ST_BIT pass per bit during
// padding, tree building and a single-leaf root walk (plus ST_POP when a parent
// pops, at most once per byte), ST_BIT, ST_W1 and ST_W2 per bit in the tree walk,
// set by the registered reads of the node tables, and the flush state.
// A new symbol stalls the sequencer while the held symbol and the output register
// are both full. Reset (synchronous, active low) restarts parsing; no clearing.
`include "huffman_stream_decoder_macros.svh"

module huffman_stream_decoder #(
    parameter int unsigned ALPHABET = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tuser,   // [0] stream_start
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] symbol
    output logic       m_axis_tlast
);
    import hsd_pkg::*;

    localparam int unsigned NODES = 2 * ALPHABET - 1;
    localparam int unsigned NW    = $clog2(NODES);
    localparam int unsigned CW    = $clog2(NODES + 1);
    localparam int unsigned PW    = $clog2(ALPHABET + 1);
    localparam int unsigned SW    = $clog2(ALPHABET);

    t_state r_state, n_state;
    t_phase r_phase, n_phase;
    logic [7:0]       r_byte, n_byte;
    logic [2:0]       r_cnt, n_cnt;
    logic [CW-1:0]    r_nfn, n_nfn;
    logic [PW-1:0]    r_sp, n_sp;
    logic [NW-1:0]    r_top_idx, n_top_idx;
    logic             r_top_side, n_top_side;
    logic [3:0]       r_lbits, n_lbits;
    logic [SYM_W-1:0] r_lval, n_lval;
    logic [NW-1:0]    r_walk, n_walk;
    logic [NW-1:0]    r_nx, n_nx;
    logic             r_root_leaf, n_root_leaf;
    logic [SYM_W-1:0] r_root_val, n_root_val;
    logic             r_pend_v, n_pend_v;
    logic [SYM_W-1:0] r_pend, n_pend;
    logic             r_ov, n_ov;
    logic [SYM_W-1:0] r_osym, n_osym;
    logic             r_olast, n_olast;

    logic             left_we, right_we, leaf_we, link_re, leaf_re;
    logic [NW-1:0]    link_addr, link_data, leaf_waddr, link_raddr, leaf_raddr;
    logic [SYM_W:0]   leaf_wdata, leaf_rdata;
    logic [NW-1:0]    rd_left, rd_right;
    logic             stk_we, stk_re;
    logic [SW-1:0]    stk_waddr, stk_raddr;
    logic [NW:0]      stk_wdata, stk_rdata;

    logic             bit_v, out_free, emit, emit_ok;
    logic [SYM_W-1:0] emit_sym;
    logic [NW-1:0]    new_node, nx;
    logic [CW-1:0]    last_node;

    hsd_node_mem #(.NODES(NODES), .NW(NW)) u_node (
        .i_clk       (i_clk),
        .i_left_we   (left_we),
        .i_right_we  (right_we),
        .i_link_addr (link_addr),
        .i_link_data (link_data),
        .i_leaf_we   (leaf_we),
        .i_leaf_waddr(leaf_waddr),
        .i_leaf_wdata(leaf_wdata),
        .i_link_re   (link_re),
        .i_link_raddr(link_raddr),
        .o_left      (rd_left),
        .o_right     (rd_right),
        .i_leaf_re   (leaf_re),
        .i_leaf_raddr(leaf_raddr),
        .o_leaf      (leaf_rdata)
    );

    hsd_stack_mem #(.DEPTH(ALPHABET), .AW(SW), .DW(NW + 1)) u_stack (
        .i_clk  (i_clk),
        .i_we   (stk_we),
        .i_waddr(stk_waddr),
        .i_wdata(stk_wdata),
        .i_re   (stk_re),
        .i_raddr(stk_raddr),
        .o_rdata(stk_rdata)
    );

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_osym;
    assign m_axis_tlast  = r_olast;

    assign bit_v     = r_byte[r_cnt];
    assign out_free  = !r_ov || m_axis_tready;
    assign emit_ok   = !r_pend_v || out_free;
    assign new_node  = r_nfn[NW-1:0];
    assign last_node = r_nfn - CW'(1);
    assign nx        = bit_v ? rd_right : rd_left;

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= PH_PAD;
            r_nfn       <= '0;
            r_sp        <= '0;
            r_lbits     <= '0;
            r_lval      <= '0;
            r_walk      <= '0;
            r_root_leaf <= 1'b0;
            r_pend_v    <= 1'b0;
            r_ov        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_nfn       <= n_nfn;
            r_sp        <= n_sp;
            r_lbits     <= n_lbits;
            r_lval      <= n_lval;
            r_walk      <= n_walk;
            r_root_leaf <= n_root_leaf;
            r_pend_v    <= n_pend_v;
            r_ov        <= n_ov;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_byte     <= n_byte;
        r_cnt      <= n_cnt;
        r_top_idx  <= n_top_idx;
        r_top_side <= n_top_side;
        r_nx       <= n_nx;
        r_root_val <= n_root_val;
        r_pend     <= n_pend;
        r_osym     <= n_osym;
        r_olast    <= n_olast;
    end

    // Sequencer: each code bit is taken from the byte in ST_BIT, ST_POP or ST_W2.
    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_byte      = r_byte;
        n_cnt       = r_cnt;
        n_nfn       = r_nfn;
        n_sp        = r_sp;
        n_top_idx   = r_top_idx;
        n_top_side  = r_top_side;
        n_lbits     = r_lbits;
        n_lval      = r_lval;
        n_walk      = r_walk;
        n_nx        = r_nx;
        n_root_leaf = r_root_leaf;
        n_root_val  = r_root_val;
        n_pend_v    = r_pend_v;
        n_pend      = r_pend;
        n_ov        = r_ov && !m_axis_tready;
        n_osym      = r_osym;
        n_olast     = r_olast;

        left_we    = 1'b0;
        right_we   = 1'b0;
        link_addr  = r_top_idx;
        link_data  = new_node;
        leaf_we    = 1'b0;
        leaf_waddr = new_node;
        leaf_wdata = '0;
        link_re    = 1'b0;
        link_raddr = r_walk;
        leaf_re    = 1'b0;
        leaf_raddr = nx;
        stk_we     = 1'b0;
        stk_waddr  = SW'(r_sp - PW'(1));
        stk_wdata  = {1'b1, r_top_idx};
        stk_re     = 1'b0;
        stk_raddr  = SW'(r_sp - PW'(2));

        emit     = 1'b0;
        emit_sym = r_root_val;

        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_byte  = s_axis_tdata;
                    n_cnt   = 3'd7;
                    n_state = ST_BIT;
                    if (s_axis_tuser) begin
                        n_phase = PH_PAD;
                        n_nfn   = '0;
                        n_sp    = '0;
                        n_lbits = '0;
                        n_lval  = '0;
                        n_walk  = '0;
                    end
                end
            end
            ST_BIT: begin
                n_state = (r_cnt == 3'd0) ? ST_FLUSH : ST_BIT;
                n_cnt   = r_cnt - 3'd1;
                if (r_phase == PH_TREE) begin
                    if (r_lbits != 4'd0) begin
                        // Gather value bits of the newest leaf.
                        n_lval  = {r_lval[SYM_W-2:0], bit_v};
                        n_lbits = r_lbits - 4'd1;
                        if (r_lbits == 4'd1) begin
                            leaf_we    = 1'b1;
                            leaf_waddr = last_node[NW-1:0];
                            leaf_wdata = {1'b1, n_lval};
                            if (last_node == '0) begin
                                n_root_leaf = 1'b1;
                                n_root_val  = n_lval;
                            end
                            if (r_sp == '0) begin
                                n_phase = PH_WALK;
                                n_walk  = '0;
                            end
                        end
                    end else if (!(r_nfn >= CW'(NODES)) &&
                                 !(!bit_v && r_sp >= PW'(ALPHABET))) begin
                        // New node: attach to the parent on top of the stack.
                        n_nfn = r_nfn + CW'(1);
                        if (r_sp != '0) begin
                            if (!r_top_side) begin
                                left_we    = 1'b1;
                                n_top_side = 1'b1;
                                if (!bit_v) begin
                                    stk_we     = 1'b1;
                                    n_top_idx  = new_node;
                                    n_top_side = 1'b0;
                                    n_sp       = r_sp + PW'(1);
                                end
                            end else begin
                                right_we = 1'b1;
                                if (!bit_v) begin
                                    n_top_idx  = new_node;
                                    n_top_side = 1'b0;
                                end else begin
                                    n_sp = r_sp - PW'(1);
                                    if (r_sp >= PW'(2)) begin
                                        stk_re  = 1'b1;
                                        n_state = ST_POP;
                                        n_cnt   = r_cnt;
                                    end
                                end
                            end
                        end else if (!bit_v) begin
                            n_top_idx  = new_node;
                            n_top_side = 1'b0;
                            n_sp       = PW'(1);
                        end
                        if (!bit_v) begin
                            leaf_we = 1'b1;
                            if (new_node == '0) begin
                                n_root_leaf = 1'b0;
                            end
                        end else begin
                            n_lbits = 4'd8;
                            n_lval  = '0;
                        end
                    end
                end else if (r_phase == PH_WALK) begin
                    if (r_root_leaf) begin
                        emit = 1'b1;
                        if (!emit_ok) begin
                            n_state = ST_BIT;
                            n_cnt   = r_cnt;
                        end
                    end else begin
                        link_re = 1'b1;
                        n_state = ST_W1;
                        n_cnt   = r_cnt;
                    end
                end else if (bit_v) begin
                    n_phase = PH_TREE;
                end
            end
            ST_POP: begin
                n_top_idx  = stk_rdata[NW-1:0];
                n_top_side = stk_rdata[NW];
                n_state    = (r_cnt == 3'd0) ? ST_FLUSH : ST_BIT;
                n_cnt      = r_cnt - 3'd1;
            end
            ST_W1: begin
                leaf_re = 1'b1;
                n_nx    = nx;
                n_state = ST_W2;
            end
            ST_W2: begin
                if (leaf_rdata[SYM_W]) begin
                    emit     = 1'b1;
                    emit_sym = leaf_rdata[SYM_W-1:0];
                    if (emit_ok) begin
                        n_walk  = '0;
                        n_state = (r_cnt == 3'd0) ? ST_FLUSH : ST_BIT;
                        n_cnt   = r_cnt - 3'd1;
                    end
                end else begin
                    n_walk  = r_nx;
                    n_state = (r_cnt == 3'd0) ? ST_FLUSH : ST_BIT;
                    n_cnt   = r_cnt - 3'd1;
                end
            end
            ST_FLUSH: begin
                if (!r_pend_v) begin
                    n_state = ST_IDLE;
                end else if (out_free) begin
                    n_ov     = 1'b1;
                    n_osym   = r_pend;
                    n_olast  = 1'b1;
                    n_pend_v = 1'b0;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // A new symbol pushes the held one out with last cleared.
        if (emit && emit_ok) begin
            if (r_pend_v) begin
                n_ov    = 1'b1;
                n_osym  = r_pend;
                n_olast = 1'b0;
            end
            n_pend_v = 1'b1;
            n_pend   = emit_sym;
        end
    end

    `HSD_ASSERT_NOW(a_idle_no_pend, i_clk, i_rst_n, s_axis_tready, !r_pend_v, "held symbol at idle")
    `HSD_ASSERT_NOW(a_sp_range, i_clk, i_rst_n, 1'b1, r_sp <= PW'(ALPHABET), "stack overrun")
    `HSD_ASSERT_NEXT(a_walk_clean, i_clk, i_rst_n, r_phase == PH_WALK && r_state != ST_IDLE, r_sp == '0 && r_lbits == 4'd0, "walk with open tree")

endmodule
